@@ rtl/pdcs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdcs_pkg
// Shared types and constants of the pulse-distance command sender.
// ----------------------------------------------------------------------------
package pdcs_pkg;

    localparam int CODE_IN_W   = 6;   // width of the code field of an item
    localparam int TICK_W      = 16;  // tick counter and length registers
    localparam int PRE_W       = 4;   // preamble pulse count register
    localparam int PIDX_W      = 5;   // pulse index within a frame
    localparam int ADDR_W      = 4;   // byte address of the register port
    localparam int DATA_W      = 32;  // register port data
    localparam int QUEUE_DEPTH = 2;   // depth of the command and result queues

    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_START = 1'b1;

    localparam logic [1:0] REG_HIGH_TICKS      = 2'd0;
    localparam logic [1:0] REG_SHORT_GAP_TICKS = 2'd1;
    localparam logic [1:0] REG_LONG_GAP_TICKS  = 2'd2;
    localparam logic [1:0] REG_PREAMBLE_PULSES = 2'd3;

    localparam logic [TICK_W-1:0] RST_HIGH_TICKS      = 16'd100;
    localparam logic [TICK_W-1:0] RST_SHORT_GAP_TICKS = 16'd5000;
    localparam logic [TICK_W-1:0] RST_LONG_GAP_TICKS  = 16'd7000;
    localparam logic [PRE_W-1:0]  RST_PREAMBLE_PULSES = 4'd5;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_HIGH = 2'd1,
        PH_LOW  = 2'd2
    } t_phase;

    typedef struct packed {
        logic [TICK_W-1:0] high_ticks;
        logic [TICK_W-1:0] short_gap_ticks;
        logic [TICK_W-1:0] long_gap_ticks;
        logic [PRE_W-1:0]  preamble_pulses;
    } t_cfg;

    typedef struct packed {
        logic                 start;
        logic [CODE_IN_W-1:0] code;
    } t_cmd;

    typedef struct packed {
        logic line_level;
        logic busy;
        logic done;
        logic rejected;
    } t_res;

endpackage

@@ rtl/pulse_distance_command_sender.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pulse_distance_command_sender
// Pulse-distance coded command transmitter with queue interfaces.
// ----------------------------------------------------------------------------
// Items are ticks or starts. A start latches a code and raises the line; the
// frame is a preamble of pulses with short gaps, CODE_BITS data pulses (MSB
// first, long gap after a one, short after a zero) and a final pulse. Each
// item yields one result with the line level, busy, done and rejected flags.
// The sequencer takes one item per clock cycle while the result queue has
// room. The command queue registers each item, the sequencer handles it
// once the result queue has room, and the result queue registers its
// result at the end of that cycle, ready to pop. The command and result
// queues hold two items each, so either side may stall without stopping the
// other. Registers: high_ticks at 0x0, short_gap_ticks at 0x4,
// long_gap_ticks at 0x8, preamble_pulses at 0xC; a new value acts on the
// running frame at once. Write only while no item is queued or unread.
// ----------------------------------------------------------------------------
module pulse_distance_command_sender
    import pdcs_pkg::*;
#(
    parameter int CODE_BITS = 6
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic                 i_kind,
    input  logic [CODE_IN_W-1:0] i_code,
    output logic                 empty,
    input  logic                 pop,
    output logic                 o_line_level,
    output logic                 o_busy_res,
    output logic                 o_done_res,
    output logic                 o_rejected,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_W-1:0]    paddr,
    input  logic [DATA_W-1:0]    pwdata,
    output logic [DATA_W-1:0]    prdata,
    output logic                 pready
);

    t_cfg       r_cfg;
    logic [1:0] w_reg_idx;
    logic       w_cfg_wr;
    logic       w_cmd_valid, w_cmd_pop;
    t_cmd       w_cmd;
    logic       w_res_full, w_res_push, w_res_empty;
    t_res       w_res, w_res_out;

    assign pready    = 1'b1;
    assign w_reg_idx = paddr[3:2];
    assign w_cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.high_ticks      <= RST_HIGH_TICKS;
            r_cfg.short_gap_ticks <= RST_SHORT_GAP_TICKS;
            r_cfg.long_gap_ticks  <= RST_LONG_GAP_TICKS;
            r_cfg.preamble_pulses <= RST_PREAMBLE_PULSES;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                REG_HIGH_TICKS:      r_cfg.high_ticks      <= pwdata[TICK_W-1:0];
                REG_SHORT_GAP_TICKS: r_cfg.short_gap_ticks <= pwdata[TICK_W-1:0];
                REG_LONG_GAP_TICKS:  r_cfg.long_gap_ticks  <= pwdata[TICK_W-1:0];
                REG_PREAMBLE_PULSES: r_cfg.preamble_pulses <= pwdata[PRE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            REG_HIGH_TICKS:      prdata = DATA_W'(r_cfg.high_ticks);
            REG_SHORT_GAP_TICKS: prdata = DATA_W'(r_cfg.short_gap_ticks);
            REG_LONG_GAP_TICKS:  prdata = DATA_W'(r_cfg.long_gap_ticks);
            REG_PREAMBLE_PULSES: prdata = DATA_W'(r_cfg.preamble_pulses);
            default:             prdata = '0;
        endcase
    end

    pdcs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .i_kind  (i_kind),
        .i_code  (i_code),
        .i_pop   (w_cmd_pop),
        .o_valid (w_cmd_valid),
        .o_cmd   (w_cmd)
    );

    pdcs_engine #(
        .CODE_BITS (CODE_BITS)
    ) u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_valid    (w_cmd_valid),
        .i_cmd      (w_cmd),
        .o_pop      (w_cmd_pop),
        .i_res_full (w_res_full),
        .o_res_push (w_res_push),
        .o_res      (w_res)
    );

    pdcs_fifo #(
        .WIDTH ($bits(t_res)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_empty (w_res_empty),
        .o_data  (w_res_out)
    );

    assign empty        = w_res_empty;
    assign o_line_level = w_res_out.line_level;
    assign o_busy_res   = w_res_out.busy;
    assign o_done_res   = w_res_out.done;
    assign o_rejected   = w_res_out.rejected;

    // An accepted item is waiting for the sequencer on the next cycle.
    a_push_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && !full |=> w_cmd_valid)
        else $error("accepted item missing from command queue");

    // The line is high only inside a frame.
    a_line_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_push && w_res.line_level |-> w_res.busy)
        else $error("line high outside a frame");

    // The frame ends with the line low and the sender idle.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_push && w_res.done |-> !w_res.busy && !w_res.rejected)
        else $error("done while busy or with a rejected start");

    // A rejected start leaves the running frame going.
    a_reject_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_push && w_res.rejected |-> w_res.busy)
        else $error("start rejected while idle");

endmodule

@@ rtl/pdcs_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdcs_fifo
// Small register queue; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module pdcs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             w_push_ok, w_pop_ok;

    assign o_full    = (r_count == FULL_CNT);
    assign o_empty   = (r_count == '0);
    assign o_data    = r_mem[r_rd_ptr];
    assign w_push_ok = i_push && !o_full;
    assign w_pop_ok  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push_ok) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PW'(1);
        end
        if (w_pop_ok) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PW'(1);
        end
        if (w_push_ok && !w_pop_ok) begin
            n_count = r_count + CW'(1);
        end else if (w_pop_ok && !w_push_ok) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push_ok) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

@@ rtl/pdcs_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdcs_front
// Accepts items, sorts them into ticks and starts, and queues them.
// ----------------------------------------------------------------------------
module pdcs_front
    import pdcs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    output logic                 o_full,
    input  logic                 i_kind,
    input  logic [CODE_IN_W-1:0] i_code,
    input  logic                 i_pop,
    output logic                 o_valid,
    output t_cmd                 o_cmd
);

    t_cmd w_cmd;
    logic w_empty;

    // A tick carries no code; zero it so the queue never holds stale bits.
    always_comb begin
        w_cmd.start = (i_kind == KIND_START);
        w_cmd.code  = (i_kind == KIND_START) ? i_code : '0;
    end

    pdcs_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (w_cmd),
        .o_full  (o_full),
        .i_pop   (i_pop),
        .o_empty (w_empty),
        .o_data  (o_cmd)
    );

    assign o_valid = !w_empty;

endmodule

@@ rtl/pdcs_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdcs_engine
// Frame sequencer: steps the line through preamble, data and final pulses.
// ----------------------------------------------------------------------------
module pdcs_engine
    import pdcs_pkg::*;
#(
    parameter int CODE_BITS = 6
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_valid,
    input  t_cmd i_cmd,
    output logic o_pop,
    input  logic i_res_full,
    output logic o_res_push,
    output t_res o_res
);

    t_phase                r_phase, n_phase;
    logic [PIDX_W-1:0]     r_pidx, n_pidx;
    logic [TICK_W-1:0]     r_tick, n_tick;
    logic [CODE_BITS-1:0]  r_code, n_code;

    logic                  w_fire;
    logic                  w_busy;
    logic [TICK_W-1:0]     w_tick_inc;
    logic [TICK_W-1:0]     w_high_len, w_short_len, w_long_len, w_gap_len;
    logic [PIDX_W-1:0]     w_last, w_pre;
    logic                  w_in_data;
    logic [PIDX_W-1:0]     w_data_off;
    logic [CODE_BITS-1:0]  w_code_sel;

    assign w_fire     = i_valid && !i_res_full;
    assign o_pop      = w_fire;
    assign o_res_push = w_fire;

    assign w_high_len  = (i_cfg.high_ticks == '0) ? TICK_W'(1) : i_cfg.high_ticks;
    assign w_short_len = (i_cfg.short_gap_ticks == '0) ? TICK_W'(1) : i_cfg.short_gap_ticks;
    assign w_long_len  = (i_cfg.long_gap_ticks == '0) ? TICK_W'(1) : i_cfg.long_gap_ticks;

    assign w_pre      = PIDX_W'(i_cfg.preamble_pulses);
    assign w_last     = w_pre + PIDX_W'(CODE_BITS);
    assign w_in_data  = (r_pidx >= w_pre);
    // Pick data bit (pulse index - preamble), MSB first; bits past the code read as zero.
    assign w_data_off = r_pidx - w_pre;
    assign w_code_sel = r_code << w_data_off;
    assign w_gap_len  = (w_in_data && w_code_sel[CODE_BITS-1]) ? w_long_len : w_short_len;
    assign w_tick_inc = r_tick + TICK_W'(1);

    always_comb begin
        n_phase = r_phase;
        n_pidx  = r_pidx;
        n_tick  = r_tick;
        n_code  = r_code;
        o_res   = '0;

        case (r_phase)
            PH_HIGH, PH_LOW: w_busy = 1'b1;
            default:         w_busy = 1'b0;
        endcase

        if (i_cmd.start) begin
            if (w_busy) begin
                o_res.rejected = 1'b1;
            end else begin
                n_phase = PH_HIGH;
                n_pidx  = '0;
                n_tick  = '0;
                n_code  = CODE_BITS'(i_cmd.code);
            end
        end else begin
            case (r_phase)
                PH_HIGH: begin
                    n_tick = w_tick_inc;
                    if (w_tick_inc >= w_high_len) begin
                        n_tick = '0;
                        if (r_pidx >= w_last) begin
                            n_phase    = PH_IDLE;
                            n_pidx     = '0;
                            o_res.done = 1'b1;
                        end else begin
                            n_phase = PH_LOW;
                        end
                    end
                end
                PH_LOW: begin
                    n_tick = w_tick_inc;
                    if (w_tick_inc >= w_gap_len) begin
                        n_tick  = '0;
                        n_pidx  = r_pidx + PIDX_W'(1);
                        n_phase = PH_HIGH;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end

        o_res.line_level = (n_phase == PH_HIGH);
        o_res.busy       = (n_phase == PH_HIGH) || (n_phase == PH_LOW);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_pidx  <= '0;
            r_tick  <= '0;
            r_code  <= '0;
        end else if (w_fire) begin
            r_phase <= n_phase;
            r_pidx  <= n_pidx;
            r_tick  <= n_tick;
            r_code  <= n_code;
        end
    end

endmodule
